>>> rtl/core/pdlf_pkg.sv
// ----------------------------------------------------------------------------
// pdlf_pkg
// Types and constants shared by the line-follow steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package pdlf_pkg;

  // Configuration port geometry
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register indexes
  localparam logic [2:0] REG_LEFT_THR  = 3'd0;
  localparam logic [2:0] REG_RIGHT_THR = 3'd1;
  localparam logic [2:0] REG_BASE      = 3'd2;
  localparam logic [2:0] REG_KP        = 3'd3;
  localparam logic [2:0] REG_KD        = 3'd4;
  localparam logic [2:0] REG_DAMP      = 3'd5;

  // Reset values
  localparam logic [7:0]  RST_LEFT_THR  = 8'd10;
  localparam logic [7:0]  RST_RIGHT_THR = 8'd10;
  localparam logic [6:0]  RST_BASE      = 7'd80;
  localparam logic [15:0] RST_KP        = 16'd256;
  localparam logic [15:0] RST_KD        = 16'd51;
  localparam logic [8:0]  RST_DAMP      = 9'd51;

  // Datapath widths
  localparam int GAIN_W  = 16;
  localparam int ABSE_W  = 8;   // |left - right|
  localparam int ABSDE_W = 9;   // |change in error|
  localparam int TICK_W  = 16;
  localparam int PROP_W  = GAIN_W + ABSE_W;   // kp * |e|
  localparam int DERV_W  = GAIN_W + ABSDE_W;  // kd * |de|
  localparam int TERM_W  = PROP_W + TICK_W;   // kp * |e| * dt
  localparam int NUM_W   = TERM_W + 2;        // signed numerator with headroom
  localparam int QUO_W   = NUM_W - 9;         // magnitude over 256
  localparam int DAMP_W  = 9;
  localparam int STEER_W = 8;

  typedef struct packed {
    logic [7:0]        left_thr;
    logic [7:0]        right_thr;
    logic [6:0]        cruise_duty;
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] kd;
    logic [DAMP_W-1:0] damp_scale;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_MAG,
    ST_DIV,
    ST_SAT,
    ST_DAMP,
    ST_DUTY,
    ST_WRITE
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/pdlf_in_if.sv
// ----------------------------------------------------------------------------
// pdlf_in_if
// Request channel carrying one pair of sensor samples and a tick stamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdlf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  left_sample;
  logic [7:0]  right_sample;
  logic [15:0] timestamp;

  modport source (output valid, output left_sample, output right_sample,
                  output timestamp, input ready);
  modport sink (input valid, input left_sample, input right_sample,
                input timestamp, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pdlf_out_if.sv
// ----------------------------------------------------------------------------
// pdlf_out_if
// Result channel carrying motor duties, steer value and direction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdlf_out_if;
  logic              valid;
  logic              ready;
  logic [6:0]        left_duty;
  logic [6:0]        right_duty;
  logic signed [7:0] steer_value;
  logic              turning_right;

  modport source (output valid, output left_duty, output right_duty,
                  output steer_value, output turning_right, input ready);
  modport sink (input valid, input left_duty, input right_duty,
                input steer_value, input turning_right, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pdlf_regs.sv
// ----------------------------------------------------------------------------
// pdlf_regs
// APB-style configuration registers for thresholds, speed and gains.
// ----------------------------------------------------------------------------
`default_nettype none

module pdlf_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pdlf_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [pdlf_pkg::DATA_W-1:0]   pwdata,
  output logic      [pdlf_pkg::DATA_W-1:0]   prdata,
  output pdlf_pkg::cfg_t                     cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_thr    <= pdlf_pkg::RST_LEFT_THR;
      cfg.right_thr   <= pdlf_pkg::RST_RIGHT_THR;
      cfg.cruise_duty <= pdlf_pkg::RST_BASE;
      cfg.kp          <= pdlf_pkg::RST_KP;
      cfg.kd          <= pdlf_pkg::RST_KD;
      cfg.damp_scale  <= pdlf_pkg::RST_DAMP;
    end else if (wr_en) begin
      case (idx)
        pdlf_pkg::REG_LEFT_THR:  cfg.left_thr    <= pwdata[7:0];
        pdlf_pkg::REG_RIGHT_THR: cfg.right_thr   <= pwdata[7:0];
        pdlf_pkg::REG_BASE:      cfg.cruise_duty <= pwdata[6:0];
        pdlf_pkg::REG_KP:        cfg.kp          <= pwdata[15:0];
        pdlf_pkg::REG_KD:        cfg.kd          <= pwdata[15:0];
        pdlf_pkg::REG_DAMP:      cfg.damp_scale  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      pdlf_pkg::REG_LEFT_THR:  prdata[7:0] = cfg.left_thr;
      pdlf_pkg::REG_RIGHT_THR: prdata[7:0] = cfg.right_thr;
      pdlf_pkg::REG_BASE:      prdata[6:0] = cfg.cruise_duty;
      pdlf_pkg::REG_KP:        prdata[15:0] = cfg.kp;
      pdlf_pkg::REG_KD:        prdata[15:0] = cfg.kd;
      pdlf_pkg::REG_DAMP:      prdata[8:0] = cfg.damp_scale;
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/pdlf_mul.sv
// ----------------------------------------------------------------------------
// pdlf_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pdlf_mul #(
  parameter int AW = 16,
  parameter int BW = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output logic                  busy,
  output logic [AW+BW-1:0]      product
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] mcand;
  logic [AW-1:0] hi;
  logic [BW-1:0] lo;
  logic [CW-1:0] cnt;
  logic [AW:0]   sum;

  // add the multiplicand when the current multiplier bit is set
  assign sum     = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(BW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      hi    <= '0;
      lo    <= b;
    end else if (busy) begin
      hi <= sum[AW:1];
      lo <= {sum[0], lo[BW-1:1]};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pdlf_div.sv
// ----------------------------------------------------------------------------
// pdlf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pdlf_div #(
  parameter int NW = 33,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [NW-1:0]      quot
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] divisor;
  logic [DW-1:0] rem;
  logic [NW-1:0] acc;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  // bring down the next dividend bit and try the subtraction
  assign trial = {rem, acc[NW-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};
  assign quot  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= den;
      rem     <= '0;
      acc     <= num;
    end else if (busy) begin
      rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
      acc <= {acc[NW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pd_line_follow_steering.sv
// ----------------------------------------------------------------------------
// pd_line_follow_steering
// PD line follower with differential drive steering.
// ----------------------------------------------------------------------------
// Usage: each request on the sensor channel carries a left and a right sample
// and a tick stamp; one result per request leaves on the drive channel with
// both motor duties, the steer value of the last PD update and the turn
// direction. Thresholds, base speed, gains and damp scale sit in an APB-style
// register file; the user must write them only while the block is idle, and
// the block itself does not enforce this. One request is handled at a time.
// A request with only one or no side on the line goes from EVAL to WRITE.
// A PD update runs an 8-step and a 9-step serial multiply side by side for
// the two gain terms, a 16-step serial multiply by the elapsed ticks, a
// 33-step restoring divide by the elapsed ticks and an 8-step multiply for
// the outer wheel damping, with sequencing states between them. Once the
// result is loaded for output, the block goes idle for the next request.
// The finished result waits in an output register; a new request is taken
// while it waits, and the next result is held back until the receiver takes
// the previous one. Reset restores the register defaults and clears the
// remembered error, time, steer and direction.
// ----------------------------------------------------------------------------
`default_nettype none

module pd_line_follow_steering #(
  parameter int DUTY_MAX = 100
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  pdlf_in_if.sink                          sensor,
  pdlf_out_if.source                       drive,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pdlf_pkg::ADDR_W-1:0] paddr,
  input  wire logic [pdlf_pkg::DATA_W-1:0] pwdata,
  output logic      [pdlf_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  localparam logic [7:0] DMAX = 8'(DUTY_MAX);

  pdlf_pkg::cfg_t   cfg;
  pdlf_pkg::state_t state, state_next;

  // latched request
  logic [7:0]  ls;
  logic [7:0]  rs;
  logic [15:0] ts;

  // controller memory
  logic [8:0]  prev_error;
  logic [15:0] prev_time;
  logic        dir;
  logic [7:0]  last_steer;

  // working registers
  logic [8:0]  e_reg;
  logic        e_neg;
  logic        de_neg;
  logic [15:0] dt;
  logic [pdlf_pkg::NUM_W-1:0] num;
  logic        num_neg;
  logic [7:0]  abs_steer;
  logic [7:0]  res_ld;
  logic [7:0]  res_rd;

  // output register
  logic        out_valid;
  logic [6:0]  out_ld;
  logic [6:0]  out_rd;
  logic [7:0]  out_steer;
  logic        out_dir;

  // control strobes
  logic accept;
  logic start_pd;
  logic start_t;
  logic start_div;
  logic start_s;
  logic load_out;

  // unit interfaces
  logic                         busy_p, busy_d, busy_t, busy_s, busy_div;
  logic [pdlf_pkg::PROP_W-1:0]  prod_p;
  logic [pdlf_pkg::DERV_W-1:0]  prod_d;
  logic [pdlf_pkg::TERM_W-1:0]  prod_t;
  logic [16:0]                  prod_s;
  logic [pdlf_pkg::QUO_W-1:0]   quo;

  // evaluation terms
  logic        lon, ron;
  logic [8:0]  e_w;
  logic [9:0]  de_w;
  logic [7:0]  abs_e;
  logic [8:0]  abs_de;
  logic [15:0] dt_raw, dt_w;
  logic [pdlf_pkg::NUM_W-1:0] q_ext, b_ext, term_a, term_b, mag;
  logic [7:0]  steer_next, abs_steer_next;
  logic [9:0]  outer;
  logic [8:0]  inner;
  logic [7:0]  outer_c, inner_c;

  pdlf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  assign lon    = ls >= cfg.left_thr;
  assign ron    = rs >= cfg.right_thr;
  assign e_w    = {1'b0, ls} - {1'b0, rs};
  assign de_w   = {e_w[8], e_w} - {prev_error[8], prev_error};
  assign abs_e  = e_w[8] ? 8'(9'd0 - e_w) : e_w[7:0];
  assign abs_de = de_w[9] ? 9'(10'd0 - de_w) : de_w[8:0];
  assign dt_raw = ts - prev_time;
  assign dt_w   = (dt_raw == 16'd0) ? 16'd1 : dt_raw;

  pdlf_mul #(.AW(pdlf_pkg::GAIN_W), .BW(pdlf_pkg::ABSE_W)) u_mul_p (
    .clk (clk), .rst (rst), .start (start_pd),
    .a (cfg.kp), .b (abs_e), .busy (busy_p), .product (prod_p)
  );

  pdlf_mul #(.AW(pdlf_pkg::GAIN_W), .BW(pdlf_pkg::ABSDE_W)) u_mul_d (
    .clk (clk), .rst (rst), .start (start_pd),
    .a (cfg.kd), .b (abs_de), .busy (busy_d), .product (prod_d)
  );

  pdlf_mul #(.AW(pdlf_pkg::PROP_W), .BW(pdlf_pkg::TICK_W)) u_mul_t (
    .clk (clk), .rst (rst), .start (start_t),
    .a (prod_p), .b (dt), .busy (busy_t), .product (prod_t)
  );

  // signed numerator and its magnitude
  assign q_ext  = {{(pdlf_pkg::NUM_W - pdlf_pkg::TERM_W){1'b0}}, prod_t};
  assign b_ext  = {{(pdlf_pkg::NUM_W - pdlf_pkg::DERV_W){1'b0}}, prod_d};
  assign term_a = e_neg ? ('0 - q_ext) : q_ext;
  assign term_b = de_neg ? ('0 - b_ext) : b_ext;
  assign mag    = num[pdlf_pkg::NUM_W-1] ? ('0 - num) : num;

  pdlf_div #(.NW(pdlf_pkg::QUO_W), .DW(pdlf_pkg::TICK_W)) u_div (
    .clk (clk), .rst (rst), .start (start_div),
    .num (mag[pdlf_pkg::NUM_W-2:8]), .den (dt),
    .busy (busy_div), .quot (quo)
  );

  // saturate to signed 8 bits
  always_comb begin
    if (!num_neg) begin
      steer_next = (|quo[pdlf_pkg::QUO_W-1:7]) ? 8'h7F : quo[7:0];
    end else if ((|quo[pdlf_pkg::QUO_W-1:8]) || (quo[7] && (|quo[6:0]))) begin
      steer_next = 8'h80;
    end else begin
      steer_next = 8'd0 - quo[7:0];
    end
  end

  assign abs_steer_next = steer_next[7] ? (8'd0 - steer_next) : steer_next;

  pdlf_mul #(.AW(pdlf_pkg::DAMP_W), .BW(pdlf_pkg::STEER_W)) u_mul_s (
    .clk (clk), .rst (rst), .start (start_s),
    .a (cfg.damp_scale), .b (abs_steer_next), .busy (busy_s), .product (prod_s)
  );

  // outer wheel gets the damped correction, inner wheel the full one
  assign outer   = {3'b0, cfg.cruise_duty} + {1'b0, prod_s[16:8]};
  assign inner   = {2'b0, cfg.cruise_duty} - {1'b0, abs_steer};
  assign outer_c = (outer > {2'b0, DMAX}) ? DMAX : outer[7:0];
  assign inner_c = inner[8] ? 8'd0 : ((inner[7:0] > DMAX) ? DMAX : inner[7:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdlf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    sensor.ready  = 1'b0;
    accept        = 1'b0;
    start_pd      = 1'b0;
    start_t       = 1'b0;
    start_div     = 1'b0;
    start_s       = 1'b0;
    load_out      = 1'b0;
    case (state)
      pdlf_pkg::ST_IDLE: begin
        sensor.ready = 1'b1;
        if (sensor.valid) begin
          accept     = 1'b1;
          state_next = pdlf_pkg::ST_EVAL;
        end
      end
      pdlf_pkg::ST_EVAL: begin
        if (lon && ron) begin
          start_pd   = 1'b1;
          state_next = pdlf_pkg::ST_MUL1;
        end else begin
          state_next = pdlf_pkg::ST_WRITE;
        end
      end
      pdlf_pkg::ST_MUL1: begin
        if (!busy_p && !busy_d) begin
          start_t    = 1'b1;
          state_next = pdlf_pkg::ST_MUL2;
        end
      end
      pdlf_pkg::ST_MUL2: begin
        if (!busy_t) begin
          state_next = pdlf_pkg::ST_SUM;
        end
      end
      pdlf_pkg::ST_SUM: state_next = pdlf_pkg::ST_MAG;
      pdlf_pkg::ST_MAG: begin
        start_div  = 1'b1;
        state_next = pdlf_pkg::ST_DIV;
      end
      pdlf_pkg::ST_DIV: begin
        if (!busy_div) begin
          state_next = pdlf_pkg::ST_SAT;
        end
      end
      pdlf_pkg::ST_SAT: begin
        start_s    = 1'b1;
        state_next = pdlf_pkg::ST_DAMP;
      end
      pdlf_pkg::ST_DAMP: begin
        if (!busy_s) begin
          state_next = pdlf_pkg::ST_DUTY;
        end
      end
      pdlf_pkg::ST_DUTY: state_next = pdlf_pkg::ST_WRITE;
      pdlf_pkg::ST_WRITE: begin
        // hold until the output register is free
        if (!out_valid || drive.ready) begin
          load_out   = 1'b1;
          state_next = pdlf_pkg::ST_IDLE;
        end
      end
      default: state_next = pdlf_pkg::ST_IDLE;
    endcase
  end

  // controller memory
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      prev_time  <= '0;
      dir        <= 1'b0;
      last_steer <= '0;
    end else begin
      if (state == pdlf_pkg::ST_EVAL && !(lon && ron)) begin
        if (lon) begin
          dir <= 1'b1;
        end else if (ron) begin
          dir <= 1'b0;
        end
      end
      if (state == pdlf_pkg::ST_SAT) begin
        prev_error <= e_reg;
        prev_time  <= ts;
        last_steer <= steer_next;
        dir        <= !steer_next[7] && (|steer_next);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ls <= sensor.left_sample;
      rs <= sensor.right_sample;
      ts <= sensor.timestamp;
    end
    if (state == pdlf_pkg::ST_EVAL) begin
      e_reg  <= e_w;
      e_neg  <= e_w[8];
      de_neg <= de_w[9];
      dt     <= dt_w;
      // hard turn toward the line
      if (lon && !ron) begin
        res_ld <= 8'd0;
        res_rd <= DMAX;
      end else if (ron && !lon) begin
        res_ld <= DMAX;
        res_rd <= 8'd0;
      end else if (dir) begin
        res_ld <= 8'd0;
        res_rd <= DMAX;
      end else begin
        res_ld <= DMAX;
        res_rd <= 8'd0;
      end
    end
    if (state == pdlf_pkg::ST_SUM) begin
      num <= term_a + term_b;
    end
    if (state == pdlf_pkg::ST_MAG) begin
      num_neg <= num[pdlf_pkg::NUM_W-1];
    end
    if (state == pdlf_pkg::ST_SAT) begin
      abs_steer <= abs_steer_next;
    end
    if (state == pdlf_pkg::ST_DUTY) begin
      if (dir) begin
        res_ld <= inner_c;
        res_rd <= outer_c;
      end else begin
        res_ld <= outer_c;
        res_rd <= inner_c;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (drive.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ld    <= res_ld[6:0];
      out_rd    <= res_rd[6:0];
      out_steer <= last_steer;
      out_dir   <= dir;
    end
  end

  assign drive.valid         = out_valid;
  assign drive.left_duty     = out_ld;
  assign drive.right_duty    = out_rd;
  assign drive.steer_value   = $signed(out_steer);
  assign drive.turning_right = out_dir;

endmodule

`default_nettype wire

>>> test/pdlf_drive_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pdlf_drive_checker
// Watches the sensor, drive and register channels of the steering block.
// Keeps its own copy of the registers and the PD state, works out the
// duties, steer and direction due for every accepted request, and compares
// each accepted result, field by field, with the oldest one outstanding.
// ----------------------------------------------------------------------------
module pdlf_drive_checker #(
  parameter int DUTY_MAX = 100
) (
  input  logic                        clk,
  input  logic                        rst,
  pdlf_in_if                          sensor,
  pdlf_out_if                         drive,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [pdlf_pkg::ADDR_W-1:0] paddr,
  input  logic [pdlf_pkg::DATA_W-1:0] pwdata,
  output int                          pending,
  output int                          fail_count
);

  typedef struct packed {
    logic [6:0]        left_duty;
    logic [6:0]        right_duty;
    logic signed [7:0] steer_value;
    logic              turning_right;
  } drive_set_t;

  pdlf_pkg::cfg_t           regs;
  logic signed [8:0]        prev_err;
  logic [15:0]              prev_time;
  logic                     heading_right;
  logic signed [7:0]        held_steer;
  drive_set_t               drive_due_q[$];

  function automatic drive_set_t steer_for_sample(input logic [7:0] lsamp,
                                                  input logic [7:0] rsamp,
                                                  input logic [15:0] stamp);
    drive_set_t res;
    logic [15:0] ticks;
    longint err, derr, dt, num, quo, base_v, damped, ld, rd;
    longint kp_v, kd_v, damp_v;
    ld = 0;
    rd = 0;
    if (lsamp >= regs.left_thr && rsamp >= regs.right_thr) begin
      err = lsamp;
      err = err - rsamp;
      derr = err - prev_err;
      ticks = stamp - prev_time;
      dt = ticks;
      if (dt == 0) dt = 1;
      kp_v = regs.kp;
      kd_v = regs.kd;
      damp_v = regs.damp_scale;
      base_v = regs.cruise_duty;
      num = kp_v * err * dt + kd_v * derr;
      // signed division truncates toward zero
      quo = num / (256 * dt);
      if (quo > 127) quo = 127;
      if (quo < -128) quo = -128;
      prev_err = err[8:0];
      prev_time = stamp;
      held_steer = quo[7:0];
      if (quo > 0) begin
        heading_right = 1'b1;
        damped = (base_v * 256 + quo * damp_v) / 256;
        ld = base_v - quo;
        rd = damped;
      end else begin
        heading_right = 1'b0;
        damped = (base_v * 256 - quo * damp_v) / 256;
        ld = damped;
        rd = base_v + quo;
      end
      ld = (ld < 0) ? 0 : (ld > DUTY_MAX) ? DUTY_MAX : ld;
      rd = (rd < 0) ? 0 : (rd > DUTY_MAX) ? DUTY_MAX : rd;
    end else if (lsamp >= regs.left_thr) begin
      rd = DUTY_MAX;
      heading_right = 1'b1;
    end else if (rsamp >= regs.right_thr) begin
      ld = DUTY_MAX;
      heading_right = 1'b0;
    end else if (heading_right) begin
      rd = DUTY_MAX;
    end else begin
      ld = DUTY_MAX;
    end
    res.left_duty = ld[6:0];
    res.right_duty = rd[6:0];
    res.steer_value = held_steer;
    res.turning_right = heading_right;
    return res;
  endfunction

  always @(posedge clk) begin
    drive_set_t got, want;
    if (rst) begin
      regs.left_thr <= pdlf_pkg::RST_LEFT_THR;
      regs.right_thr <= pdlf_pkg::RST_RIGHT_THR;
      regs.cruise_duty <= pdlf_pkg::RST_BASE;
      regs.kp <= pdlf_pkg::RST_KP;
      regs.kd <= pdlf_pkg::RST_KD;
      regs.damp_scale <= pdlf_pkg::RST_DAMP;
      prev_err = '0;
      prev_time = '0;
      heading_right = 1'b0;
      held_steer = '0;
      drive_due_q.delete();
      pending <= 0;
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          pdlf_pkg::REG_LEFT_THR:  regs.left_thr <= pwdata[7:0];
          pdlf_pkg::REG_RIGHT_THR: regs.right_thr <= pwdata[7:0];
          pdlf_pkg::REG_BASE:      regs.cruise_duty <= pwdata[6:0];
          pdlf_pkg::REG_KP:        regs.kp <= pwdata[15:0];
          pdlf_pkg::REG_KD:        regs.kd <= pwdata[15:0];
          pdlf_pkg::REG_DAMP:      regs.damp_scale <= pwdata[8:0];
          default: ;
        endcase
      end
      if (drive.valid && drive.ready) begin
        got.left_duty = drive.left_duty;
        got.right_duty = drive.right_duty;
        got.steer_value = drive.steer_value;
        got.turning_right = drive.turning_right;
        if (drive_due_q.size() == 0) begin
          $error("drive result with no request outstanding");
          fail_count++;
        end else begin
          want = drive_due_q.pop_front();
          if (got.left_duty !== want.left_duty) begin
            $error("left_duty: expected %0d, got %0d", want.left_duty, got.left_duty);
            fail_count++;
          end
          if (got.right_duty !== want.right_duty) begin
            $error("right_duty: expected %0d, got %0d", want.right_duty, got.right_duty);
            fail_count++;
          end
          if (got.steer_value !== want.steer_value) begin
            $error("steer_value: expected %0d, got %0d", want.steer_value,
                   got.steer_value);
            fail_count++;
          end
          if (got.turning_right !== want.turning_right) begin
            $error("turning_right: expected %0d, got %0d", want.turning_right,
                   got.turning_right);
            fail_count++;
          end
        end
      end
      if (sensor.valid && sensor.ready)
        drive_due_q.push_back(steer_for_sample(sensor.left_sample, sensor.right_sample,
                                               sensor.timestamp));
      pending <= drive_due_q.size();
    end
  end

endmodule

>>> test/tb_pd_line_follow_steering.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pd_line_follow_steering
// Drives sensor requests and register writes into the steering block under
// several register settings and several patterns of sender gaps and
// receiver stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_pd_line_follow_steering;

  localparam int DUTY_MAX     = 100;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int BLOCK_ITEMS  = 185;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [pdlf_pkg::ADDR_W-1:0]   paddr;
  logic [pdlf_pkg::DATA_W-1:0]   pwdata;
  logic [pdlf_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  int                            pending;
  int                            fail_count;
  int                            cycles = 0;
  int                            gap_pct = 0;
  int                            stall_pct = 0;
  logic [7:0]                    left_thr = pdlf_pkg::RST_LEFT_THR;
  logic [7:0]                    right_thr = pdlf_pkg::RST_RIGHT_THR;
  logic [15:0]                   stamp = '0;

  int gap_by_mode[4]   = '{0, 59, 0, 27};
  int stall_by_mode[4] = '{0, 0, 59, 27};
  // left thr, right thr, base, kp, kd, damp scale
  logic [31:0] cfg_table[4][6] = '{
    '{0,   0,   100, 65535, 65535, 256},
    '{255, 255, 0,   0,     0,     0},
    '{128, 64,  127, 1024,  40000, 511},
    '{10,  10,  80,  256,   51,    51}
  };

  pdlf_in_if  sensor_if();
  pdlf_out_if drive_if();

  pd_line_follow_steering #(.DUTY_MAX(DUTY_MAX)) dut (
    .clk     (clk),
    .rst     (rst),
    .sensor  (sensor_if),
    .drive   (drive_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pdlf_drive_checker #(.DUTY_MAX(DUTY_MAX)) checker_i (
    .clk        (clk),
    .rst        (rst),
    .sensor     (sensor_if),
    .drive      (drive_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    drive_if.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("pd_line_follow_steering verification failed");
      $finish;
    end
  end

  // Hold the request until the block takes it; leave valid high afterwards.
  task automatic offer_sample(input logic [7:0] lsamp, input logic [7:0] rsamp,
                              input logic [15:0] ts);
    while ($urandom_range(99) < gap_pct) begin
      sensor_if.valid <= 1'b0;
      @(posedge clk);
    end
    sensor_if.valid <= 1'b1;
    sensor_if.left_sample <= lsamp;
    sensor_if.right_sample <= rsamp;
    sensor_if.timestamp <= ts;
    do @(posedge clk); while (!sensor_if.ready);
  endtask

  task automatic drain_results();
    sensor_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] on_sample(input logic [7:0] thr);
    return 8'($urandom_range(255, thr));
  endfunction

  // Below threshold is impossible at zero; fall back to any value.
  function automatic logic [7:0] off_sample(input logic [7:0] thr);
    return (thr == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(thr - 1, 0));
  endfunction

  task automatic random_samples(input int count);
    int lv, rv, pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        // same stamp again: no elapsed ticks
      end else if (pick < 80) begin
        stamp = stamp + 16'($urandom_range(64, 1));
      end else if (pick < 90) begin
        stamp = stamp + 16'($urandom_range(65535));
      end else begin
        stamp = 16'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 62) begin
        lv = on_sample(left_thr);
        if ($urandom_range(1)) begin
          // keep the error small: right sample within 8 of the left one before clamping
          rv = lv + int'($urandom_range(16)) - 8;
          if (rv < int'(right_thr)) rv = int'(right_thr);
          if (rv > 255) rv = 255;
        end else begin
          rv = on_sample(right_thr);
        end
      end else if (pick < 76) begin
        lv = on_sample(left_thr);
        rv = off_sample(right_thr);
      end else if (pick < 90) begin
        lv = off_sample(left_thr);
        rv = on_sample(right_thr);
      end else begin
        lv = off_sample(left_thr);
        rv = off_sample(right_thr);
      end
      offer_sample(8'(lv), 8'(rv), stamp);
    end
  endtask

  initial begin
    logic [31:0] vals[6];
    int blk;
    int k;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sensor_if.valid = 1'b0;
    sensor_if.left_sample = '0;
    sensor_if.right_sample = '0;
    sensor_if.timestamp = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed run under the reset register values
    offer_sample(8'd10, 8'd10, 16'd0);       // both exactly at threshold, no ticks
    offer_sample(8'd255, 8'd10, 16'd5);      // largest positive error
    offer_sample(8'd10, 8'd255, 16'd5);      // largest negative error, no ticks
    offer_sample(8'd255, 8'd255, 16'd65535);
    offer_sample(8'd100, 8'd90, 16'd100);
    offer_sample(8'd90, 8'd100, 16'd200);
    offer_sample(8'd9, 8'd9, 16'd300);       // neither on, heading left
    offer_sample(8'd200, 8'd0, 16'd301);     // left only
    offer_sample(8'd0, 8'd0, 16'd302);       // neither on, heading right
    offer_sample(8'd0, 8'd255, 16'd303);     // right only
    offer_sample(8'd9, 8'd9, 16'd304);
    offer_sample(8'd120, 8'd100, 16'd65530);
    offer_sample(8'd100, 8'd120, 16'd4);     // tick count wraps
    offer_sample(8'd11, 8'd10, 16'd4);
    offer_sample(8'd255, 8'd0, 16'd65535);
    offer_sample(8'd0, 8'd255, 16'd0);
    drain_results();

    for (blk = 0; blk < 8; blk++) begin
      gap_pct = 0;
      stall_pct = 0;
      if (blk < 4) begin
        for (k = 0; k < 6; k++) vals[k] = cfg_table[blk][k];
      end else begin
        vals[pdlf_pkg::REG_LEFT_THR] = $urandom_range(255);
        vals[pdlf_pkg::REG_RIGHT_THR] = $urandom_range(255);
        vals[pdlf_pkg::REG_BASE] = $urandom_range(127);
        vals[pdlf_pkg::REG_KP] = $urandom_range(65535);
        vals[pdlf_pkg::REG_KD] = $urandom_range(65535);
        vals[pdlf_pkg::REG_DAMP] = $urandom_range(511);
      end
      write_reg(pdlf_pkg::REG_LEFT_THR, vals[pdlf_pkg::REG_LEFT_THR]);
      write_reg(pdlf_pkg::REG_RIGHT_THR, vals[pdlf_pkg::REG_RIGHT_THR]);
      write_reg(pdlf_pkg::REG_BASE, vals[pdlf_pkg::REG_BASE]);
      write_reg(pdlf_pkg::REG_KP, vals[pdlf_pkg::REG_KP]);
      write_reg(pdlf_pkg::REG_KD, vals[pdlf_pkg::REG_KD]);
      write_reg(pdlf_pkg::REG_DAMP, vals[pdlf_pkg::REG_DAMP]);
      left_thr = vals[pdlf_pkg::REG_LEFT_THR][7:0];
      right_thr = vals[pdlf_pkg::REG_RIGHT_THR][7:0];
      gap_pct = gap_by_mode[(blk + 1) % 4];
      stall_pct = stall_by_mode[(blk + 1) % 4];
      random_samples(BLOCK_ITEMS);
      drain_results();
    end

    stall_pct = 0;
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("pd_line_follow_steering verification clean");
    end else begin
      $display("pd_line_follow_steering verification failed");
    end
    $finish;
  end

endmodule
